[sv/eab_pkg.sv]
// Shared constants, types and fixed-point helpers for the Euler-angle basis block.
package eab_pkg;

    // Angle and result formats.
    localparam int ANGLE_BITS   = 16;
    localparam int FRAC_BITS    = 14;
    localparam int OUT_BITS     = FRAC_BITS + 2;
    localparam int SUM_W        = OUT_BITS + 1;
    localparam int PROD_W       = 2 * OUT_BITS;

    // CORDIC datapath: x and y carry a scale of 2^32, z a full turn of 2^32.
    localparam int CORDIC_STEPS = 32;
    localparam int XY_W         = 35;
    localparam int Z_W          = 34;
    localparam logic [31:0] CORDIC_GAIN_INV = 32'd2608131496;

    // Pipeline depth: CORDIC steps, sine/cosine stage, four product stages.
    localparam int PIPE_LAT     = CORDIC_STEPS + 1 + 4;

    localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    localparam logic signed [PROD_W:0] PROD_HALF = (PROD_W + 1)'(1 << (FRAC_BITS - 1));
    localparam logic signed [SUM_W-1:0] ONE_SUM = SUM_W'(1 << FRAC_BITS);
    localparam logic signed [SUM_W-1:0] MINUS_ONE_SUM = -ONE_SUM;

    // Sine and cosine of one angle in Q1.FRAC_BITS.
    typedef struct packed {
        logic signed [OUT_BITS-1:0] s;
        logic signed [OUT_BITS-1:0] c;
    } sincos_t;

    // Round a Q2.2F product back to Q1.F, half an LSB toward plus infinity.
    function automatic logic signed [SUM_W-1:0] round_prod(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W:0] t;
        logic signed [PROD_W:0] sh;
        t  = {p[PROD_W-1], p} + PROD_HALF;
        sh = t >>> FRAC_BITS;
        return sh[SUM_W-1:0];
    endfunction

    // Clamp a value to plus or minus one.
    function automatic logic signed [OUT_BITS-1:0] sat_out(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] r;
        if (v > ONE_SUM)
        begin
            r = ONE_SUM;
        end
        else if (v < MINUS_ONE_SUM)
        begin
            r = MINUS_ONE_SUM;
        end
        else
        begin
            r = v;
        end
        return r[OUT_BITS-1:0];
    endfunction

endpackage

[sv/euler_angles_to_basis_vectors.sv]
// Path from input transfer to result: 32 CORDIC steps, one sine/cosine
// stage, two multiply and two round stages for the products.
// Throughput: one item per cycle; the whole pipeline holds while a result is stalled.
// The CORDIC steps, one per register stage, set the depth of the pipeline.
// Reset (rst_n low, asynchronous) clears every valid bit; data registers keep no reset.
// Top level: three CORDIC pipelines and the product network for the basis vectors.
module euler_angles_to_basis_vectors (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [eab_pkg::ANGLE_BITS-1:0]      pitch_angle,
    input  logic [eab_pkg::ANGLE_BITS-1:0]      yaw_angle,
    input  logic [eab_pkg::ANGLE_BITS-1:0]      roll_angle,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [eab_pkg::OUT_BITS-1:0] forward_x,
    output logic signed [eab_pkg::OUT_BITS-1:0] forward_y,
    output logic signed [eab_pkg::OUT_BITS-1:0] forward_z,
    output logic signed [eab_pkg::OUT_BITS-1:0] right_x,
    output logic signed [eab_pkg::OUT_BITS-1:0] right_y,
    output logic signed [eab_pkg::OUT_BITS-1:0] right_z,
    output logic signed [eab_pkg::OUT_BITS-1:0] up_x,
    output logic signed [eab_pkg::OUT_BITS-1:0] up_y,
    output logic signed [eab_pkg::OUT_BITS-1:0] up_z
);
    import eab_pkg::*;

    logic                pipe_en;
    logic [PIPE_LAT-1:0] vld_reg;
    logic [PIPE_LAT-1:0] vld_next;

    // The pipeline advances unless a finished result is held by the receiver.
    assign pipe_en  = !(vld_reg[PIPE_LAT-1] && out_stall);
    assign in_stall = !pipe_en;

    assign vld_next = {vld_reg[PIPE_LAT-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (pipe_en)
        begin
            vld_reg <= vld_next;
        end
    end

    // Sine and cosine of each angle.
    sincos_t sc_p;
    sincos_t sc_y;
    sincos_t sc_r;

    eab_cordic u_cordic_pitch (.clk(clk), .en(pipe_en), .angle(pitch_angle), .sc(sc_p));
    eab_cordic u_cordic_yaw   (.clk(clk), .en(pipe_en), .angle(yaw_angle),   .sc(sc_y));
    eab_cordic u_cordic_roll  (.clk(clk), .en(pipe_en), .angle(roll_angle),  .sc(sc_r));

    // First multiply stage: ten pairwise products; pitch sine and yaw terms ride along.
    logic signed [PROD_W-1:0]   m_srsp_reg, m_crsp_reg, m_cpcy_reg, m_cpsy_reg, m_crsy_reg;
    logic signed [PROD_W-1:0]   m_crcy_reg, m_srsy_reg, m_srcy_reg, m_srcp_reg, m_crcp_reg;
    logic signed [OUT_BITS-1:0] sp1_reg, sy1_reg, cy1_reg;

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            m_srsp_reg <= sc_r.s * sc_p.s;
            m_crsp_reg <= sc_r.c * sc_p.s;
            m_cpcy_reg <= sc_p.c * sc_y.c;
            m_cpsy_reg <= sc_p.c * sc_y.s;
            m_crsy_reg <= sc_r.c * sc_y.s;
            m_crcy_reg <= sc_r.c * sc_y.c;
            m_srsy_reg <= sc_r.s * sc_y.s;
            m_srcy_reg <= sc_r.s * sc_y.c;
            m_srcp_reg <= sc_r.s * sc_p.c;
            m_crcp_reg <= sc_r.c * sc_p.c;
            sp1_reg    <= sc_p.s;
            sy1_reg    <= sc_y.s;
            cy1_reg    <= sc_y.c;
        end
    end

    // First round stage: products back to Q1.FRAC_BITS.
    logic signed [SUM_W-1:0]    srsp_reg, crsp_reg, cpcy_reg, cpsy_reg, crsy_reg;
    logic signed [SUM_W-1:0]    crcy_reg, srsy_reg, srcy_reg, srcp_reg, crcp_reg;
    logic signed [OUT_BITS-1:0] sp2_reg, sy2_reg, cy2_reg;

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            srsp_reg <= round_prod(m_srsp_reg);
            crsp_reg <= round_prod(m_crsp_reg);
            cpcy_reg <= round_prod(m_cpcy_reg);
            cpsy_reg <= round_prod(m_cpsy_reg);
            crsy_reg <= round_prod(m_crsy_reg);
            crcy_reg <= round_prod(m_crcy_reg);
            srsy_reg <= round_prod(m_srsy_reg);
            srcy_reg <= round_prod(m_srcy_reg);
            srcp_reg <= round_prod(m_srcp_reg);
            crcp_reg <= round_prod(m_crcp_reg);
            sp2_reg  <= sp1_reg;
            sy2_reg  <= sy1_reg;
            cy2_reg  <= cy1_reg;
        end
    end

    // Second multiply stage: triple products with yaw; the rest rides along.
    logic signed [PROD_W-1:0]   m_srspcy_reg, m_srspsy_reg, m_crspcy_reg, m_crspsy_reg;
    logic signed [SUM_W-1:0]    cpcy3_reg, cpsy3_reg, crsy3_reg, crcy3_reg;
    logic signed [SUM_W-1:0]    srsy3_reg, srcy3_reg, srcp3_reg, crcp3_reg;
    logic signed [OUT_BITS-1:0] sp3_reg;

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            m_srspcy_reg <= $signed(srsp_reg[OUT_BITS-1:0]) * cy2_reg;
            m_srspsy_reg <= $signed(srsp_reg[OUT_BITS-1:0]) * sy2_reg;
            m_crspcy_reg <= $signed(crsp_reg[OUT_BITS-1:0]) * cy2_reg;
            m_crspsy_reg <= $signed(crsp_reg[OUT_BITS-1:0]) * sy2_reg;
            cpcy3_reg    <= cpcy_reg;
            cpsy3_reg    <= cpsy_reg;
            crsy3_reg    <= crsy_reg;
            crcy3_reg    <= crcy_reg;
            srsy3_reg    <= srsy_reg;
            srcy3_reg    <= srcy_reg;
            srcp3_reg    <= srcp_reg;
            crcp3_reg    <= crcp_reg;
            sp3_reg      <= sp2_reg;
        end
    end

    // Output stage: round, combine and clamp each component.
    logic signed [OUT_BITS-1:0] fx_reg, fy_reg, fz_reg, rx_reg, ry_reg, rz_reg;
    logic signed [OUT_BITS-1:0] ux_reg, uy_reg, uz_reg;
    logic signed [SUM_W-1:0]    sp_ext;

    assign sp_ext = SUM_W'(sp3_reg);

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            fx_reg <= sat_out(cpcy3_reg);
            fy_reg <= sat_out(cpsy3_reg);
            fz_reg <= sat_out(-sp_ext);
            rx_reg <= sat_out(crsy3_reg - round_prod(m_srspcy_reg));
            ry_reg <= sat_out(-round_prod(m_srspsy_reg) - crcy3_reg);
            rz_reg <= sat_out(-srcp3_reg);
            ux_reg <= sat_out(round_prod(m_crspcy_reg) + srsy3_reg);
            uy_reg <= sat_out(round_prod(m_crspsy_reg) - srcy3_reg);
            uz_reg <= sat_out(crcp3_reg);
        end
    end

    assign out_valid = vld_reg[PIPE_LAT-1];
    assign forward_x = fx_reg;
    assign forward_y = fy_reg;
    assign forward_z = fz_reg;
    assign right_x   = rx_reg;
    assign right_y   = ry_reg;
    assign right_z   = rz_reg;
    assign up_x      = ux_reg;
    assign up_y      = uy_reg;
    assign up_z      = uz_reg;

`ifndef SYNTHESIS
    // An accepted transfer enters the first stage.
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> vld_reg[0])
        else $error("accepted transfer did not enter the pipeline");

    // A held pipeline keeps every valid bit.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !pipe_en |=> (vld_reg == $past(vld_reg)))
        else $error("valid bits moved while the pipeline was held");

    // Delivered forward_x, right_y and up_x never exceed plus or minus one.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((forward_x <= ONE_SUM) && (forward_x >= MINUS_ONE_SUM) &&
                       (right_y <= ONE_SUM) && (right_y >= MINUS_ONE_SUM) &&
                       (up_x <= ONE_SUM) && (up_x >= MINUS_ONE_SUM)))
        else $error("result component out of range");
`endif

endmodule

[sv/eab_cordic.sv]
// Pipelined rotation-mode CORDIC giving the sine and cosine of one binary angle.
module eab_cordic (
    input  logic                            clk,
    input  logic                            en,
    input  logic [eab_pkg::ANGLE_BITS-1:0]  angle,
    output eab_pkg::sincos_t                sc
);
    import eab_pkg::*;

    localparam int RND_SHIFT = 32 - FRAC_BITS;
    localparam logic signed [XY_W:0] XY_HALF = (XY_W + 1)'(1 << (RND_SHIFT - 1));
    localparam logic signed [XY_W:0] XY_ONE  = (XY_W + 1)'(1 << FRAC_BITS);
    localparam logic signed [XY_W:0] XY_MONE = -XY_ONE;

    logic signed [XY_W-1:0] x_reg [CORDIC_STEPS];
    logic signed [XY_W-1:0] y_reg [CORDIC_STEPS];
    logic signed [Z_W-1:0]  z_reg [CORDIC_STEPS];
    logic [1:0]             quad_reg [CORDIC_STEPS];
    sincos_t                sc_reg;

    // Starting vector: gain-compensated x, residue of the quadrant in z.
    logic signed [XY_W-1:0] x_init;
    logic signed [Z_W-1:0]  z_init;
    assign x_init = signed'({{(XY_W - 32){1'b0}}, CORDIC_GAIN_INV});
    assign z_init = signed'({{(Z_W - 30){1'b0}}, angle[ANGLE_BITS-3:0],
                             {(32 - ANGLE_BITS){1'b0}}});

    // One micro-rotation per pipeline stage.
    genvar i;
    generate
        for (i = 0; i < CORDIC_STEPS; i++)
        begin : g_step
            logic signed [XY_W-1:0] x_in;
            logic signed [XY_W-1:0] y_in;
            logic signed [Z_W-1:0]  z_in;
            logic [1:0]             q_in;
            logic signed [Z_W-1:0]  atan_val;

            if (i == 0)
            begin : g_first
                assign x_in = x_init;
                assign y_in = '0;
                assign z_in = z_init;
                assign q_in = angle[ANGLE_BITS-1:ANGLE_BITS-2];
            end
            else
            begin : g_next
                assign x_in = x_reg[i-1];
                assign y_in = y_reg[i-1];
                assign z_in = z_reg[i-1];
                assign q_in = quad_reg[i-1];
            end

            assign atan_val = signed'({{(Z_W - 32){1'b0}}, ATAN_TAB[i]});

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    if (z_in >= 0)
                    begin
                        x_reg[i] <= x_in - (y_in >>> i);
                        y_reg[i] <= y_in + (x_in >>> i);
                        z_reg[i] <= z_in - atan_val;
                    end
                    else
                    begin
                        x_reg[i] <= x_in + (y_in >>> i);
                        y_reg[i] <= y_in - (x_in >>> i);
                        z_reg[i] <= z_in + atan_val;
                    end
                    quad_reg[i] <= q_in;
                end
            end
        end
    endgenerate

    // Round to Q1.FRAC_BITS and clamp to plus or minus one.
    function automatic logic signed [OUT_BITS-1:0] to_q(input logic signed [XY_W-1:0] v);
        logic signed [XY_W:0] t;
        logic signed [XY_W:0] sh;
        logic signed [XY_W:0] r;
        t  = {v[XY_W-1], v} + XY_HALF;
        sh = t >>> RND_SHIFT;
        if (sh > XY_ONE)
        begin
            r = XY_ONE;
        end
        else if (sh < XY_MONE)
        begin
            r = XY_MONE;
        end
        else
        begin
            r = sh;
        end
        return r[OUT_BITS-1:0];
    endfunction

    logic signed [OUT_BITS-1:0] c_q;
    logic signed [OUT_BITS-1:0] s_q;
    sincos_t                    sc_next;

    assign c_q = to_q(x_reg[CORDIC_STEPS-1]);
    assign s_q = to_q(y_reg[CORDIC_STEPS-1]);

    // Map the first-quadrant result back to the quadrant of the angle.
    always_comb
    begin
        unique case (quad_reg[CORDIC_STEPS-1])
            2'd0:
            begin
                sc_next.c = c_q;
                sc_next.s = s_q;
            end
            2'd1:
            begin
                sc_next.c = -s_q;
                sc_next.s = c_q;
            end
            2'd2:
            begin
                sc_next.c = -c_q;
                sc_next.s = -s_q;
            end
            default:
            begin
                sc_next.c = s_q;
                sc_next.s = -c_q;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sc_reg <= sc_next;
        end
    end

    assign sc = sc_reg;

endmodule
